>>> design/sleep_delta_queue_assert.svh
// assertion macros shared by the timeout queue rtl
// expects a clock and an active-high reset from the including module
`ifndef SLEEP_DELTA_QUEUE_ASSERT_SVH
`define SLEEP_DELTA_QUEUE_ASSERT_SVH

// condition holds in the same cycle
`define SDQ_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sleep_delta_queue assertion failed");

// condition holds in the next cycle
`define SDQ_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sleep_delta_queue assertion failed");

`endif

>>> design/sdq_pkg.sv
// shared constants and types for the sleep delta queue
// no dependencies
`default_nettype none

package sdq_pkg;

  // default sizes
  localparam int QUEUE_DEPTH_DEF = 16;
  localparam int TIME_BITS_DEF   = 16;

  // most threads that leave on one item
  localparam int MAX_OUT = 16;

  // field widths of the items
  localparam int FUNC_W   = 2;
  localparam int THREAD_W = 8;
  localparam int WAIT_W   = 16;
  localparam int COUNT_W  = 5;

  // operation codes
  localparam logic [FUNC_W-1:0] FUNC_ENQ     = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_TICK    = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_RELEASE = 2'd2;

  // status codes
  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_FULL = 1'b1;

  // result item, woken_valid in bit 0
  typedef struct packed {
    logic                status;
    logic [COUNT_W-1:0]  released_total;
    logic                timed_out;
    logic [THREAD_W-1:0] woken_thread;
    logic                woken_valid;
  } result_t;

endpackage

`default_nettype wire

>>> design/sleep_delta_queue.sv
// sleep delta queue: bounded timeout queue kept as a delta list in one ram
// depends on sdq_pkg, sdq_ram and sleep_delta_queue_assert.svh
//
// Input stream s_*: one item per operation, s_tuser carries the operation
// (enqueue, tick, release), s_tdata the thread, the wait and the release
// count. The block takes one item at a time; s_tready is high only while
// no item is being worked on.
// Output stream m_*: result items, m_tlast on the final result of an item.
// An enqueue gives one result, a tick one per expired thread (none if
// nothing expires), a release one per released thread or one empty result.
// Entries live in a circular ram (head pointer plus occupancy) with one
// read and one write a cycle; every entry read waits on the registered
// read of the ram. An enqueue with a finite wait walks the entries ahead
// of it and moves the later ones a place towards the tail, a tick works
// on the head, and a release works through one released thread after
// another.
// A stalled receiver holds the single output register and the sequencer
// waits on it; no result is dropped.
// Reset empties the queue at once; the ram is not cleared, as only entries
// below the occupancy are ever read.
`default_nettype none

module sleep_delta_queue #(
  parameter int QUEUE_DEPTH = sdq_pkg::QUEUE_DEPTH_DEF,
  parameter int TIME_BITS   = sdq_pkg::TIME_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // input items
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [31:0] s_tdata,  // thread_id[7:0], wait_time[23:8], release_count[28:24]
  input  wire logic [1:0]  s_tuser,  // func[1:0]
  // result items
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [15:0]      m_tdata,  // woken_valid[0], woken_thread[8:1], timed_out[9],
                                     // released_total[14:10], status[15]
  output logic             m_tlast
);

  localparam int AW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int TB = TIME_BITS;
  localparam int EW = TIME_BITS + sdq_pkg::THREAD_W + 1;
  localparam int NW = sdq_pkg::COUNT_W;
  localparam int WW = (TIME_BITS > sdq_pkg::WAIT_W) ? TIME_BITS : sdq_pkg::WAIT_W;
  localparam logic [WW-1:0] TMAX_W = WW'((64'd1 << TIME_BITS) - 64'd1);
  localparam logic [CW-1:0] DEPTH_C = CW'(QUEUE_DEPTH);
  localparam logic [NW-1:0] MAX_OUT_C = NW'(sdq_pkg::MAX_OUT);

  // sequencer states
  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_ENQ_RD  = 4'd1;
  localparam logic [3:0] S_ENQ_CHK = 4'd2;
  localparam logic [3:0] S_SH_RD   = 4'd3;
  localparam logic [3:0] S_SH_WR   = 4'd4;
  localparam logic [3:0] S_INS_SAV = 4'd5;
  localparam logic [3:0] S_INS_NEW = 4'd6;
  localparam logic [3:0] S_RESP    = 4'd7;
  localparam logic [3:0] S_TK_RD   = 4'd8;
  localparam logic [3:0] S_TK_CHK  = 4'd9;
  localparam logic [3:0] S_TK_LAST = 4'd10;
  localparam logic [3:0] S_RL_RD   = 4'd11;
  localparam logic [3:0] S_RL_CHK0 = 4'd12;
  localparam logic [3:0] S_RL_RD1  = 4'd13;
  localparam logic [3:0] S_RL_CHK1 = 4'd14;
  localparam logic [3:0] S_RL_EMIT = 4'd15;

  // ram slot of an offset from the head
  function automatic logic [AW-1:0] slot(input logic [AW-1:0] base,
                                         input logic [CW-1:0] off);
    logic [CW:0] sum;
    sum = (CW+1)'(base) + (CW+1)'(off);
    if (sum >= (CW+1)'(QUEUE_DEPTH)) begin
      sum = sum - (CW+1)'(QUEUE_DEPTH);
    end
    return sum[AW-1:0];
  endfunction

  // control registers
  logic [3:0]    state, state_next;
  logic [AW-1:0] head, head_next;
  logic [CW-1:0] occ, occ_next;
  logic [CW-1:0] rd_idx, rd_idx_next;
  logic [CW-1:0] pos, pos_next;
  logic [NW-1:0] cnt, cnt_next;
  logic [NW-1:0] lim, lim_next;
  logic          out_valid, out_valid_next;

  // payload registers
  logic [TB-1:0]               t, t_next;
  logic [sdq_pkg::THREAD_W-1:0] new_thread, new_thread_next;
  logic [sdq_pkg::THREAD_W-1:0] sav_thread, sav_thread_next;
  logic [TB-1:0]               sav_delta, sav_delta_next;
  logic                        sav_forever, sav_forever_next;
  logic                        resp_full, resp_full_next;
  sdq_pkg::result_t            out_res, out_res_next;
  logic                        out_last, out_last_next;

  // ram ports
  logic          wr_en;
  logic [CW-1:0] wr_off;
  logic [EW-1:0] wr_data;
  logic [EW-1:0] rd_data;

  // input fields
  logic [sdq_pkg::FUNC_W-1:0]   in_func;
  logic [sdq_pkg::THREAD_W-1:0] in_thread;
  logic [sdq_pkg::WAIT_W-1:0]   in_wait;
  logic [NW-1:0]                in_count;
  logic [WW-1:0]                wait_ext;
  logic [TB-1:0]                t_init;

  // entry fields read back
  logic [sdq_pkg::THREAD_W-1:0] rd_thread;
  logic [TB-1:0]                rd_delta;
  logic                         rd_forever;

  logic          accept;
  logic          out_free;
  logic [AW-1:0] head_inc;
  logic [TB-1:0] delta_dec;
  logic          rl_last;

  assign in_func   = s_tuser;
  assign in_thread = s_tdata[7:0];
  assign in_wait   = s_tdata[23:8];
  assign in_count  = s_tdata[28:24];

  // saturate the wait to the delta width
  assign wait_ext = WW'(in_wait);
  assign t_init   = (wait_ext > TMAX_W) ? TB'(TMAX_W) : TB'(wait_ext);

  assign rd_thread  = rd_data[sdq_pkg::THREAD_W-1:0];
  assign rd_delta   = rd_data[sdq_pkg::THREAD_W +: TB];
  assign rd_forever = rd_data[EW-1];

  assign s_tready = (state == S_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign out_free = !out_valid || m_tready;
  assign head_inc = (head == AW'(QUEUE_DEPTH - 1)) ? '0 : head + 1'b1;
  assign delta_dec = (rd_delta != '0) ? rd_delta - 1'b1 : rd_delta;
  assign rl_last  = ((cnt + 1'b1) == lim) || (occ == CW'(1));

  // entry store
  sdq_ram #(
    .WIDTH(EW),
    .DEPTH(QUEUE_DEPTH)
  ) u_ram (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(slot(head, wr_off)),
    .wr_data(wr_data),
    .rd_addr(slot(head, rd_idx)),
    .rd_data(rd_data)
  );

  // sequencer
  always_comb begin
    state_next       = state;
    head_next        = head;
    occ_next         = occ;
    rd_idx_next      = rd_idx;
    pos_next         = pos;
    cnt_next         = cnt;
    lim_next         = lim;
    t_next           = t;
    new_thread_next  = new_thread;
    sav_thread_next  = sav_thread;
    sav_delta_next   = sav_delta;
    sav_forever_next = sav_forever;
    resp_full_next   = resp_full;
    out_res_next     = out_res;
    out_last_next    = out_last;
    out_valid_next   = out_valid && !m_tready;
    wr_en            = 1'b0;
    wr_off           = '0;
    wr_data          = '0;

    unique case (state)
      S_IDLE: begin
        if (accept) begin
          unique case (in_func)
            sdq_pkg::FUNC_ENQ: begin
              new_thread_next = in_thread;
              t_next          = t_init;
              pos_next        = '0;
              resp_full_next  = sdq_pkg::STATUS_OK;
              if (occ == DEPTH_C) begin
                resp_full_next = sdq_pkg::STATUS_FULL;
                state_next     = S_RESP;
              end else if (t_init == '0) begin
                // wait forever: append behind everything
                wr_en      = 1'b1;
                wr_off     = occ;
                wr_data    = {1'b1, TB'(0), in_thread};
                occ_next   = occ + 1'b1;
                state_next = S_RESP;
              end else if (occ == '0) begin
                state_next = S_INS_NEW;
              end else begin
                rd_idx_next = '0;
                state_next  = S_ENQ_RD;
              end
            end
            sdq_pkg::FUNC_TICK: begin
              cnt_next    = '0;
              rd_idx_next = '0;
              if (occ != '0) begin
                state_next = S_TK_RD;
              end
            end
            sdq_pkg::FUNC_RELEASE: begin
              lim_next       = (in_count > MAX_OUT_C) ? MAX_OUT_C : in_count;
              cnt_next       = '0;
              rd_idx_next    = '0;
              resp_full_next = sdq_pkg::STATUS_OK;
              if (in_count == '0 || occ == '0) begin
                state_next = S_RESP;
              end else begin
                state_next = S_RL_RD;
              end
            end
            default: begin
              state_next = S_IDLE;
            end
          endcase
        end
      end

      S_ENQ_RD: begin
        state_next = S_ENQ_CHK;
      end

      // walk: subtract deltas until the new deadline falls before an entry
      S_ENQ_CHK: begin
        if (!rd_forever && (t >= rd_delta)) begin
          t_next   = t - rd_delta;
          pos_next = pos + 1'b1;
          if ((pos + 1'b1) == occ) begin
            state_next = S_INS_NEW;
          end else begin
            rd_idx_next = pos + 1'b1;
            state_next  = S_ENQ_RD;
          end
        end else begin
          sav_thread_next  = rd_thread;
          sav_forever_next = rd_forever;
          sav_delta_next   = rd_forever ? rd_delta : rd_delta - t;
          if ((occ - 1'b1) > pos) begin
            rd_idx_next = occ - 1'b1;
            state_next  = S_SH_RD;
          end else begin
            state_next = S_INS_SAV;
          end
        end
      end

      S_SH_RD: begin
        state_next = S_SH_WR;
      end

      // move one entry a place towards the tail
      S_SH_WR: begin
        wr_en   = 1'b1;
        wr_off  = rd_idx + 1'b1;
        wr_data = rd_data;
        if ((rd_idx - 1'b1) > pos) begin
          rd_idx_next = rd_idx - 1'b1;
          state_next  = S_SH_RD;
        end else begin
          state_next = S_INS_SAV;
        end
      end

      S_INS_SAV: begin
        wr_en      = 1'b1;
        wr_off     = pos + 1'b1;
        wr_data    = {sav_forever, sav_delta, sav_thread};
        state_next = S_INS_NEW;
      end

      S_INS_NEW: begin
        wr_en      = 1'b1;
        wr_off     = pos;
        wr_data    = {1'b0, t, new_thread};
        occ_next   = occ + 1'b1;
        state_next = S_RESP;
      end

      // single result of an enqueue or an empty release
      S_RESP: begin
        if (out_free) begin
          out_valid_next              = 1'b1;
          out_res_next                = '0;
          out_res_next.status         = resp_full;
          out_last_next               = 1'b1;
          state_next                  = S_IDLE;
        end
      end

      S_TK_RD: begin
        state_next = S_TK_CHK;
      end

      // head check on tick; a taken thread waits as pending until the next
      // head shows whether it is the last one
      S_TK_CHK: begin
        if (cnt == '0) begin
          if (rd_forever) begin
            state_next = S_IDLE;
          end else if (delta_dec != '0) begin
            wr_en      = 1'b1;
            wr_off     = '0;
            wr_data    = {1'b0, delta_dec, rd_thread};
            state_next = S_IDLE;
          end else begin
            sav_thread_next = rd_thread;
            head_next       = head_inc;
            occ_next        = occ - 1'b1;
            cnt_next        = NW'(1);
            if (occ == CW'(1) || MAX_OUT_C == NW'(1)) begin
              state_next = S_TK_LAST;
            end else begin
              state_next = S_TK_RD;
            end
          end
        end else if (!rd_forever && rd_delta == '0) begin
          if (out_free) begin
            out_valid_next              = 1'b1;
            out_res_next                = '0;
            out_res_next.woken_valid    = 1'b1;
            out_res_next.woken_thread   = sav_thread;
            out_res_next.timed_out      = 1'b1;
            out_last_next               = 1'b0;
            sav_thread_next             = rd_thread;
            head_next                   = head_inc;
            occ_next                    = occ - 1'b1;
            cnt_next                    = cnt + 1'b1;
            if (occ == CW'(1) || (cnt + 1'b1) == MAX_OUT_C) begin
              state_next = S_TK_LAST;
            end else begin
              state_next = S_TK_RD;
            end
          end
        end else begin
          state_next = S_TK_LAST;
        end
      end

      S_TK_LAST: begin
        if (out_free) begin
          out_valid_next            = 1'b1;
          out_res_next              = '0;
          out_res_next.woken_valid  = 1'b1;
          out_res_next.woken_thread = sav_thread;
          out_res_next.timed_out    = 1'b1;
          out_last_next             = 1'b1;
          state_next                = S_IDLE;
        end
      end

      S_RL_RD: begin
        state_next = S_RL_CHK0;
      end

      // capture the head; fetch the next entry when its delta must grow
      S_RL_CHK0: begin
        sav_thread_next  = rd_thread;
        sav_delta_next   = rd_delta;
        sav_forever_next = rd_forever;
        if (occ > CW'(1) && !rd_forever) begin
          rd_idx_next = CW'(1);
          state_next  = S_RL_RD1;
        end else begin
          state_next = S_RL_EMIT;
        end
      end

      S_RL_RD1: begin
        state_next = S_RL_CHK1;
      end

      // fold the removed delta into the next finite entry
      S_RL_CHK1: begin
        if (!rd_forever) begin
          wr_en   = 1'b1;
          wr_off  = CW'(1);
          wr_data = {1'b0, rd_delta + sav_delta, rd_thread};
        end
        state_next = S_RL_EMIT;
      end

      S_RL_EMIT: begin
        if (out_free) begin
          out_valid_next            = 1'b1;
          out_res_next              = '0;
          out_res_next.woken_valid  = 1'b1;
          out_res_next.woken_thread = sav_thread;
          out_res_next.released_total = rl_last ? cnt + 1'b1 : '0;
          out_last_next             = rl_last;
          head_next                 = head_inc;
          occ_next                  = occ - 1'b1;
          cnt_next                  = cnt + 1'b1;
          rd_idx_next               = '0;
          state_next                = rl_last ? S_IDLE : S_RL_RD;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      head      <= '0;
      occ       <= '0;
      rd_idx    <= '0;
      pos       <= '0;
      cnt       <= '0;
      lim       <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      head      <= head_next;
      occ       <= occ_next;
      rd_idx    <= rd_idx_next;
      pos       <= pos_next;
      cnt       <= cnt_next;
      lim       <= lim_next;
      out_valid <= out_valid_next;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    t           <= t_next;
    new_thread  <= new_thread_next;
    sav_thread  <= sav_thread_next;
    sav_delta   <= sav_delta_next;
    sav_forever <= sav_forever_next;
    resp_full   <= resp_full_next;
    out_res     <= out_res_next;
    out_last    <= out_last_next;
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = out_res;
  assign m_tlast  = out_last;

  // checks
  `include "sleep_delta_queue_assert.svh"

  `SDQ_ASSERT_NOW(a_occ_bound, clk, rst, 1'b1, occ <= DEPTH_C)
  `SDQ_ASSERT_NOW(a_head_bound, clk, rst, 1'b1, head <= AW'(QUEUE_DEPTH - 1))
  `SDQ_ASSERT_NEXT(a_full_keeps, clk, rst,
    accept && in_func == sdq_pkg::FUNC_ENQ && occ == DEPTH_C, occ == $past(occ))
  `SDQ_ASSERT_NOW(a_full_result, clk, rst,
    out_valid && out_res.status, out_last && !out_res.woken_valid)

endmodule

`default_nettype wire

>>> design/sdq_ram.sv
// generic single-port-write, single-port-read ram with registered read
// no dependencies
`default_nettype none

module sdq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read, old data on a clash
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

>>> verif/sdq_wakeup_checker.sv
// scoreboard for the sleep delta queue: tracks the delta list from accepted input items,
// predicts every result item and compares it field by field with the output stream
// depends on sdq_pkg
module sdq_wakeup_checker (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  input  wire logic        s_tready,
  input  wire logic [31:0] s_tdata,  // thread_id[7:0], wait_time[23:8], release_count[28:24]
  input  wire logic [1:0]  s_tuser,  // func[1:0]
  input  wire logic        m_tvalid,
  input  wire logic        m_tready,
  input  wire logic [15:0] m_tdata,  // woken_valid[0], woken_thread[8:1], timed_out[9],
                                     // released_total[14:10], status[15]
  input  wire logic        m_tlast,
  output int               mismatches,
  output int               pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH = sdq_pkg::QUEUE_DEPTH_DEF;
  localparam int TW    = sdq_pkg::TIME_BITS_DEF;
  localparam int THW   = sdq_pkg::THREAD_W;

  typedef struct packed {
    sdq_pkg::result_t res;
    logic             last;
  } outcome_t;

  // shadow copy of the delta list
  logic [THW-1:0] slot_thread  [DEPTH];
  logic [TW-1:0]  slot_delta   [DEPTH];
  logic           slot_forever [DEPTH];
  int             slot_count;

  outcome_t         awaited_results [$];
  outcome_t         batch [sdq_pkg::MAX_OUT];
  outcome_t         want;
  sdq_pkg::result_t got;

  function automatic outcome_t make_outcome(logic valid, logic [THW-1:0] thr, logic tout,
                                            logic [sdq_pkg::COUNT_W-1:0] total,
                                            logic status, logic last);
    outcome_t o;
    o.res.woken_valid    = valid;
    o.res.woken_thread   = thr;
    o.res.timed_out      = tout;
    o.res.released_total = total;
    o.res.status         = status;
    o.last               = last;
    return o;
  endfunction

  // remove the head entry, everything behind it moves up one place
  task automatic drop_head();
    for (int i = 1; i < slot_count; i++) begin
      slot_thread[i-1]  = slot_thread[i];
      slot_delta[i-1]   = slot_delta[i];
      slot_forever[i-1] = slot_forever[i];
    end
    if (slot_count > 0) slot_count--;
  endtask

  task automatic insert_slot(input int pos, input logic [THW-1:0] thr,
                             input logic [TW-1:0] dl, input logic fv);
    for (int i = slot_count; i > pos; i--) begin
      slot_thread[i]  = slot_thread[i-1];
      slot_delta[i]   = slot_delta[i-1];
      slot_forever[i] = slot_forever[i-1];
    end
    slot_thread[pos]  = thr;
    slot_delta[pos]   = dl;
    slot_forever[pos] = fv;
    slot_count++;
  endtask

  // apply one operation to the shadow list and queue up the results it causes
  task automatic compute_wakeups(input logic [sdq_pkg::FUNC_W-1:0] op,
                                 input logic [THW-1:0] thr,
                                 input logic [sdq_pkg::WAIT_W-1:0] wt,
                                 input logic [sdq_pkg::COUNT_W-1:0] cnt);
    int pos;
    int n;
    int lim;
    logic [TW-1:0] rem;
    n = 0;
    case (op)
      sdq_pkg::FUNC_ENQ: begin
        if (slot_count >= DEPTH) begin
          awaited_results.push_back(make_outcome(1'b0, '0, 1'b0, '0,
                                                 sdq_pkg::STATUS_FULL, 1'b1));
        end else begin
          if (wt == 0) begin
            // wait forever goes behind everything
            insert_slot(slot_count, thr, '0, 1'b1);
          end else begin
            rem = (wt > {TW{1'b1}}) ? {TW{1'b1}} : TW'(wt);
            pos = 0;
            // walk past earlier or equal deadlines, consuming their deltas
            while (pos < slot_count && !slot_forever[pos] && rem >= slot_delta[pos]) begin
              rem = rem - slot_delta[pos];
              pos++;
            end
            if (pos < slot_count && !slot_forever[pos]) slot_delta[pos] = slot_delta[pos] - rem;
            insert_slot(pos, thr, rem, 1'b0);
          end
          awaited_results.push_back(make_outcome(1'b0, '0, 1'b0, '0,
                                                 sdq_pkg::STATUS_OK, 1'b1));
        end
      end
      sdq_pkg::FUNC_TICK: begin
        if (slot_count > 0 && !slot_forever[0]) begin
          if (slot_delta[0] != 0) slot_delta[0] = slot_delta[0] - 1'b1;
          while (n < sdq_pkg::MAX_OUT && slot_count > 0 && !slot_forever[0] &&
                 slot_delta[0] == 0) begin
            batch[n] = make_outcome(1'b1, slot_thread[0], 1'b1, '0, sdq_pkg::STATUS_OK, 1'b0);
            n++;
            drop_head();
          end
        end
      end
      sdq_pkg::FUNC_RELEASE: begin
        lim = (cnt > sdq_pkg::MAX_OUT) ? sdq_pkg::MAX_OUT : int'(cnt);
        while (n < lim && slot_count > 0) begin
          // hand the remaining time on so later deadlines stay put
          if (!slot_forever[0] && slot_count > 1 && !slot_forever[1])
            slot_delta[1] = slot_delta[1] + slot_delta[0];
          batch[n] = make_outcome(1'b1, slot_thread[0], 1'b0, '0, sdq_pkg::STATUS_OK, 1'b0);
          n++;
          drop_head();
        end
        if (n == 0)
          awaited_results.push_back(make_outcome(1'b0, '0, 1'b0, '0,
                                                 sdq_pkg::STATUS_OK, 1'b1));
        else batch[n-1].res.released_total = sdq_pkg::COUNT_W'(n);
      end
      default: ;
    endcase
    if (n > 0) batch[n-1].last = 1'b1;
    for (int i = 0; i < n; i++) awaited_results.push_back(batch[i]);
  endtask

  // watch both channels at each edge
  always @(posedge clk) begin
    if (rst) begin
      slot_count = 0;
      awaited_results.delete();
      mismatches = 0;
    end else begin
      if (s_tvalid && s_tready)
        compute_wakeups(s_tuser, s_tdata[7:0], s_tdata[23:8], s_tdata[28:24]);
      if (m_tvalid && m_tready) begin
        got = sdq_pkg::result_t'(m_tdata);
        if (awaited_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result item: tdata %h tlast %b at %0t", m_tdata, m_tlast, $time);
        end else begin
          want = awaited_results.pop_front();
          if (got.woken_valid !== want.res.woken_valid ||
              got.woken_thread !== want.res.woken_thread ||
              got.timed_out !== want.res.timed_out ||
              got.released_total !== want.res.released_total ||
              got.status !== want.res.status ||
              m_tlast !== want.last) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch at %0t: expected valid %b thread %0d timeout %b total %0d",
                       $time, want.res.woken_valid, want.res.woken_thread,
                       want.res.timed_out, want.res.released_total,
                       " status %b last %b / got valid %b thread %0d timeout %b",
                       want.res.status, want.last, got.woken_valid, got.woken_thread,
                       got.timed_out, " total %0d status %b last %b",
                       got.released_total, got.status, m_tlast);
          end
        end
      end
    end
    pending = awaited_results.size();
  end

endmodule

>>> verif/sleep_delta_queue_tb.sv
// top of the sleep delta queue testbench: clock, reset, item stimulus and verdict
// depends on sdq_pkg, sleep_delta_queue and sdq_wakeup_checker
module sleep_delta_queue_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FW  = sdq_pkg::FUNC_W;
  localparam int THW = sdq_pkg::THREAD_W;
  localparam int WTW = sdq_pkg::WAIT_W;
  localparam int CNW = sdq_pkg::COUNT_W;

  // operation code the block ignores
  localparam logic [FW-1:0] FUNC_UNUSED = 2'd3;

  logic        clk;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic [31:0] s_tdata  = '0;
  logic [1:0]  s_tuser  = '0;
  logic        m_tready = 1'b0;
  wire         s_tready;
  wire         m_tvalid;
  wire  [15:0] m_tdata;
  wire         m_tlast;
  int          fails;
  int          pending;
  int          burst_left = 0;

  sleep_delta_queue uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  sdq_wakeup_checker wake_check (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tlast    (m_tlast),
    .mismatches (fails),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  // mostly short waits so ticks expire threads, some forever and some very long
  function automatic logic [WTW-1:0] pick_wait();
    int r;
    r = $urandom_range(0, 99);
    if (r < 15) return '0;
    if (r < 70) return WTW'($urandom_range(1, 6));
    if (r < 90) return WTW'($urandom_range(7, 40));
    return WTW'($urandom_range(1, 65535));
  endfunction

  // a small pool of ids now and then, so duplicates occur
  function automatic logic [THW-1:0] pick_thread();
    if ($urandom_range(0, 9) < 4) return THW'($urandom_range(0, 7));
    return THW'($urandom_range(0, 255));
  endfunction

  function automatic logic [CNW-1:0] pick_count();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return CNW'($urandom_range(1, 4));
    if (r < 80) return CNW'($urandom_range(0, 31));
    return CNW'($urandom_range(16, 31));
  endfunction

  // offer one item and hold it until accepted; bursts with gaps between them
  task automatic offer(input logic [FW-1:0] op, input logic [THW-1:0] thr,
                       input logic [WTW-1:0] wt, input logic [CNW-1:0] cnt);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      if ($urandom_range(0, 2) != 0) begin
        s_tvalid <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk);
      end
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {3'b000, cnt, wt, thr};
    do @(posedge clk); while (!s_tready);
  endtask

  // receiver pacing, with one long hold-off so the block backs up
  initial begin : rx_pace
    int cyc;
    int mode;
    int mode_left;
    int hold_left;
    cyc = 0;
    mode = 0;
    mode_left = 0;
    hold_left = 0;
    forever begin
      @(posedge clk);
      cyc++;
      if (cyc == 1500) hold_left = 400;
      if (mode_left == 0) begin
        mode = $urandom_range(0, 2);
        mode_left = $urandom_range(20, 200);
      end
      mode_left--;
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        case (mode)
          0: m_tready <= 1'b1;
          1: m_tready <= 1'($urandom_range(0, 1));
          default: m_tready <= (cyc % 4 == 0);
        endcase
      end
    end
  end

  initial begin : stimulus
    int sent;
    int r;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // empty queue: release gives one empty result, tick gives none
    offer(sdq_pkg::FUNC_RELEASE, 8'h00, 16'h0000, 5'd31);
    offer(sdq_pkg::FUNC_TICK, 8'hff, 16'hffff, 5'd0);
    offer(FUNC_UNUSED, 8'h5a, 16'h1234, 5'd3);

    // id and wait extremes, equal deadlines leave in arrival order
    offer(sdq_pkg::FUNC_ENQ, 8'hff, 16'hffff, 5'd0);
    offer(sdq_pkg::FUNC_ENQ, 8'h00, 16'h0000, 5'd0);
    offer(sdq_pkg::FUNC_ENQ, 8'haa, 16'h0001, 5'd0);
    offer(sdq_pkg::FUNC_ENQ, 8'h55, 16'h0001, 5'd0);
    offer(sdq_pkg::FUNC_TICK, 8'h00, 16'h0000, 5'd0);

    // release of nothing on a busy queue, then more than is queued
    offer(sdq_pkg::FUNC_RELEASE, 8'h00, 16'h0000, 5'd0);
    offer(sdq_pkg::FUNC_RELEASE, 8'h00, 16'h0000, 5'd16);

    // fill to the brim, refuse one more, then expire the lot in one tick
    for (int k = 0; k < sdq_pkg::QUEUE_DEPTH_DEF; k++)
      offer(sdq_pkg::FUNC_ENQ, THW'(8'hc0 + k), 16'h0001, 5'd0);
    offer(sdq_pkg::FUNC_ENQ, 8'h77, 16'h0002, 5'd0);
    offer(sdq_pkg::FUNC_TICK, 8'h00, 16'h0000, 5'd0);

    // random mix, with the odd run of enqueues that overfills the queue
    sent = 0;
    while (sent < 470) begin
      r = $urandom_range(0, 99);
      if (r < 3) begin
        for (int k = 0; k < 18; k++)
          offer(sdq_pkg::FUNC_ENQ, pick_thread(), pick_wait(), pick_count());
        sent += 18;
      end else if (r < 45) begin
        offer(sdq_pkg::FUNC_ENQ, pick_thread(), pick_wait(), pick_count());
        sent++;
      end else if (r < 78) begin
        offer(sdq_pkg::FUNC_TICK, pick_thread(), WTW'($urandom), pick_count());
        sent++;
      end else if (r < 96) begin
        offer(sdq_pkg::FUNC_RELEASE, pick_thread(), WTW'($urandom), pick_count());
        sent++;
      end else begin
        offer(FUNC_UNUSED, pick_thread(), WTW'($urandom), pick_count());
        sent++;
      end
    end
    s_tvalid <= 1'b0;

    // drain, then allow for an item that produced nothing
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (fails == 0 && pending == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule

>>> sleep_delta_queue.f
+incdir+design
design/sdq_pkg.sv
design/sdq_ram.sv
design/sleep_delta_queue.sv
verif/sdq_wakeup_checker.sv
verif/sleep_delta_queue_tb.sv
